// ----- design/gsta_pkg.sv -----
package gsta_pkg;

  localparam int WorkerSlotsDef = 1024;
  localparam int TaskSlotsDef   = 1024;
  localparam int MaxCopiesDef   = 16;
  localparam int IdxW           = 10;
  localparam int SumW           = 48;
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

  localparam logic ActTask   = 1'b0;
  localparam logic ActWorker = 1'b1;

  typedef struct packed {
    logic        action;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] radius;
    logic [4:0]  copies;
    logic [31:0] begin_time;
    logic [31:0] duration;
    logic [15:0] price;
  } in_item_t;

  typedef struct packed {
    logic            matched;
    logic [IdxW-1:0] partner_index;
    logic [IdxW-1:0] new_index;
    logic            status;
    logic [SumW-1:0] total_utility;
    logic            last;
  } out_item_t;

  // One stored entry as it moves through the scan pipeline.
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] rad;
    logic [31:0] wb;
    logic [31:0] we;
    logic [15:0] price;
    logic        taken;
  } entry_t;

endpackage

// ----- design/gsta_if.sv -----
interface gsta_in_if;
  import gsta_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gsta_out_if;
  import gsta_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/gsta_cell.sv -----
// One pipeline cell of the scan chain: takes the candidate from its left
// neighbor, does its share of the feasibility work, hands it on.
module gsta_cell #(
  parameter int STAGE = 0,
  parameter int IW    = 16
) (
  input  logic                  clk,
  input  logic                  v_in,
  input  logic [IW-1:0]         idx_in,
  input  gsta_pkg::entry_t      cand_in,
  input  gsta_pkg::entry_t      self_in,
  input  logic                  self_worker,
  input  logic [64:0]           acc_in,
  output logic                  v_out,
  output logic [IW-1:0]         idx_out,
  output gsta_pkg::entry_t      cand_out,
  output logic [64:0]           acc_out
);
  import gsta_pkg::*;

  // stage 0: abs deltas, window check
  // stage 1: squares of the deltas
  // stage 2: radius square, sum of squares vs radius square
  logic [64:0] acc_nxt;
  entry_t      w, t;
  logic [15:0] dx, dy;
  logic [32:0] d2;

  always_comb begin
    w = self_worker ? self_in : cand_in;
    t = self_worker ? cand_in : self_in;
    acc_nxt = acc_in;
    dx = '0;
    dy = '0;
    d2 = '0;
    case (STAGE)
      0: begin
        dx = (w.x > t.x) ? w.x - t.x : t.x - w.x;
        dy = (w.y > t.y) ? w.y - t.y : t.y - w.y;
        acc_nxt        = '0;
        acc_nxt[15:0]  = dx;
        acc_nxt[31:16] = dy;
        acc_nxt[64]    = (w.wb < t.we) && (t.wb < w.we);
      end
      1: begin
        acc_nxt[31:0]  = 32'(acc_in[15:0]) * 32'(acc_in[15:0]);
        acc_nxt[63:32] = 32'(acc_in[31:16]) * 32'(acc_in[31:16]);
        acc_nxt[64]    = acc_in[64];
      end
      default: begin
        d2 = 33'(acc_in[31:0]) + 33'(acc_in[63:32]);
        acc_nxt = '0;
        acc_nxt[0] = acc_in[64] &&
                     (d2 <= 33'(32'(w.rad) * 32'(w.rad)));
      end
    endcase
  end

  always_ff @(posedge clk) begin
    v_out    <= v_in;
    idx_out  <= idx_in;
    cand_out <= cand_in;
    acc_out  <= acc_nxt;
  end
endmodule

// ----- design/greedy_spatial_task_assigner.sv -----
// Greedy spatial task assigner.
// Input channel (in_*): one arrival per transaction, a task or a worker.
// A worker of capacity c becomes c unit copies (0 counts as 1, capped at
// MAX_COPIES); a task is one unit. Each unit yields one result transaction
// on the output channel (out_*); last marks the final unit of an arrival.
// Each unit with a slot is stored in its own table as the opposite table is read
// one entry per cycle from its memory and fed through a three-cell chain
// (deltas and window, squares, distance compare); a best-score register
// keeps the first highest feasible untaken candidate.
// Each unit passes slot pick, the scan of the opposite table's filled
// entries, the chain drain, commit and output; a dropped unit goes from
// slot pick straight to commit and output. The units of an arrival are
// handled one after another, and the opposite table's fill count sets the scan length. One arrival is
// processed at a time; in_ready is high only while no arrival is in flight.
// Reset clears fill counts, the utility sum and control; table contents
// are never used above the fill count, so they need no clearing pass.
// When the receiver stalls the result is held in the output register and
// the next unit waits until it is taken.
module greedy_spatial_task_assigner #(
  parameter int WORKER_SLOTS = gsta_pkg::WorkerSlotsDef,
  parameter int TASK_SLOTS   = gsta_pkg::TaskSlotsDef,
  parameter int MAX_COPIES   = gsta_pkg::MaxCopiesDef
) (
  input  logic       clk,
  input  logic       rst_n,
  gsta_in_if.sink    in_ch,
  gsta_out_if.source out_ch
);
  import gsta_pkg::*;

  localparam int WAW = $clog2(WORKER_SLOTS);
  localparam int TAW = $clog2(TASK_SLOTS);
  localparam int AW  = (WAW > TAW) ? WAW : TAW;
  localparam int FW  = AW + 1;
  localparam int CW  = $clog2(MAX_COPIES + 1);

  typedef enum logic [2:0] {S_IDLE, S_STORE, S_SCAN, S_DRAIN, S_COMMIT, S_OUT}
    state_t;

  state_t state_r;
  entry_t self_r;
  logic   worker_r;
  logic [CW-1:0] left_r;
  logic [FW-1:0] wfill_r, tfill_r, scan_r, lim_r;
  logic [AW-1:0] slot_r;
  logic [SumW-1:0] sum_r;
  logic found_r;
  logic [31:0] best_r;
  logic [AW-1:0] bidx_r;
  logic [3:0] drain_r;
  logic drop_r;
  out_item_t out_r;
  logic out_v_r;

  // tables
  entry_t wmem [WORKER_SLOTS];
  entry_t tmem [TASK_SLOTS];
  logic   wtk [WORKER_SLOTS];
  logic   ttk [TASK_SLOTS];
  entry_t rd_r;
  logic   rd_tk_r;
  logic   rd_v_r;
  logic [AW-1:0] rd_idx_r;
  entry_t rd_cand;

  // merge the taken flag into the entry read from the table
  always_comb begin
    rd_cand = rd_r;
    rd_cand.taken = rd_tk_r;
  end

  logic [31:0] endv;
  logic [32:0] endsum;
  logic [CW-1:0] ncp;
  always_comb begin
    endsum = 33'(in_ch.data.begin_time) + 33'(in_ch.data.duration);
    endv = endsum[32] ? 32'hFFFF_FFFF : endsum[31:0];
    if (in_ch.data.action == ActTask || in_ch.data.copies == 5'd0) ncp = CW'(1);
    else if (32'(in_ch.data.copies) > MAX_COPIES) ncp = CW'(MAX_COPIES);
    else ncp = CW'(in_ch.data.copies);
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

  // chain of cells
  logic v0, v1, v2, v3;
  logic [AW-1:0] i1, i2, i3;
  entry_t c1, c2, c3;
  logic [64:0] a1, a2, a3;
  assign v0 = rd_v_r;
  gsta_cell #(.STAGE(0), .IW(AW)) u_c0 (.clk, .v_in(v0), .idx_in(rd_idx_r),
    .cand_in(rd_cand), .self_in(self_r), .self_worker(worker_r), .acc_in(65'd0),
    .v_out(v1), .idx_out(i1), .cand_out(c1), .acc_out(a1));
  gsta_cell #(.STAGE(1), .IW(AW)) u_c1 (.clk, .v_in(v1), .idx_in(i1),
    .cand_in(c1), .self_in(self_r), .self_worker(worker_r), .acc_in(a1),
    .v_out(v2), .idx_out(i2), .cand_out(c2), .acc_out(a2));
  gsta_cell #(.STAGE(2), .IW(AW)) u_c2 (.clk, .v_in(v2), .idx_in(i2),
    .cand_in(c2), .self_in(self_r), .self_worker(worker_r), .acc_in(a2),
    .v_out(v3), .idx_out(i3), .cand_out(c3), .acc_out(a3));

  // score register after the chain, compare in the cycle after
  logic [31:0] sc_r;
  logic ok_r, sv_r;
  logic [AW-1:0] si_r;
  always_ff @(posedge clk) begin
    sc_r <= 32'(c3.price) * 32'(self_r.price);
    ok_r <= a3[0] && !c3.taken;
    sv_r <= v3;
    si_r <= i3;
  end

  logic [SumW:0] add;
  assign add = (SumW+1)'(sum_r) + (SumW+1)'(best_r);

  // memory ports; store the unit on the first scan cycle, once its slot is known
  always_ff @(posedge clk) begin
    rd_v_r <= (state_r == S_SCAN) && !drop_r && (scan_r < lim_r);
    rd_idx_r <= AW'(scan_r);
    if (worker_r) begin
      rd_r <= tmem[TAW'(scan_r)];
      rd_tk_r <= ttk[TAW'(scan_r)];
    end else begin
      rd_r <= wmem[WAW'(scan_r)];
      rd_tk_r <= wtk[WAW'(scan_r)];
    end
    if (state_r == S_SCAN && !drop_r && scan_r == '0) begin
      if (worker_r) begin
        wmem[WAW'(slot_r)] <= self_r;
        wtk[WAW'(slot_r)] <= 1'b0;
      end else begin
        tmem[TAW'(slot_r)] <= self_r;
        ttk[TAW'(slot_r)] <= 1'b0;
      end
    end
    if (state_r == S_COMMIT && found_r) begin
      if (worker_r) begin
        wtk[WAW'(slot_r)] <= 1'b1;
        ttk[TAW'(bidx_r)] <= 1'b1;
      end else begin
        ttk[TAW'(slot_r)] <= 1'b1;
        wtk[WAW'(bidx_r)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wfill_r <= '0;
      tfill_r <= '0;
      sum_r   <= '0;
      out_v_r <= 1'b0;
      left_r  <= '0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_v_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_ch.valid) begin
          worker_r <= in_ch.data.action;
          self_r <= '{x: in_ch.data.pos_x, y: in_ch.data.pos_y,
                      rad: in_ch.data.radius, wb: in_ch.data.begin_time,
                      we: endv, price: in_ch.data.price, taken: 1'b0};
          left_r <= ncp;
          state_r <= S_STORE;
        end
        S_STORE: if (!out_v_r || out_ch.ready) begin
          // take a slot, or drop when the table is full
          found_r <= 1'b0;
          best_r  <= '0;
          bidx_r  <= '0;
          scan_r  <= '0;
          drain_r <= '0;
          if (worker_r) begin
            drop_r <= (wfill_r >= FW'(WORKER_SLOTS));
            slot_r <= AW'(wfill_r);
            lim_r  <= tfill_r;
          end else begin
            drop_r <= (tfill_r >= FW'(TASK_SLOTS));
            slot_r <= AW'(tfill_r);
            lim_r  <= wfill_r;
          end
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (drop_r) state_r <= S_COMMIT;
          else if (scan_r >= lim_r) state_r <= S_DRAIN;
          else scan_r <= scan_r + FW'(1);
        end
        S_DRAIN: begin
          drain_r <= drain_r + 4'd1;
          if (drain_r == 4'd7) state_r <= S_COMMIT;
        end
        S_COMMIT: begin
          if (!drop_r) begin
            if (worker_r) wfill_r <= wfill_r + FW'(1);
            else tfill_r <= tfill_r + FW'(1);
          end
          if (found_r)
            sum_r <= add[SumW] ? SumMax : add[SumW-1:0];
          state_r <= S_OUT;
        end
        default: begin
          out_r.matched <= found_r;
          out_r.partner_index <= found_r ? IdxW'(bidx_r) : '0;
          out_r.new_index <= drop_r ? '0 : IdxW'(slot_r);
          out_r.status <= drop_r;
          out_r.total_utility <= sum_r;
          out_r.last <= (left_r == CW'(1));
          out_v_r <= 1'b1;
          left_r <= left_r - CW'(1);
          state_r <= (left_r == CW'(1)) ? S_IDLE : S_STORE;
        end
      endcase
      // best-candidate tracker, strict greater keeps the lowest index
      if (sv_r && ok_r && sc_r > best_r) begin
        best_r  <= sc_r;
        bidx_r  <= si_r;
        found_r <= 1'b1;
      end
    end
  end

  a_drop_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.status |-> !out_ch.data.matched)
    else $error("dropped unit reported as matched");
  a_sum_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> sum_r >= $past(sum_r))
    else $error("utility sum decreased");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> left_r == '0)
    else $error("input ready with units outstanding");
endmodule
